### hdl/tlbp_pkg.sv
// Package: shared types and constants for the two-level branch predictor with BTB.
package tlbp_pkg;

   // Command codes carried by req_cmd
   typedef enum logic [1:0] {
      CMD_PREDICT = 2'd0,
      CMD_UPDATE  = 2'd1,
      CMD_INIT    = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_INDEX_BITS   = 3'd0,
      REG_HISTORY_BITS = 3'd1,
      REG_TAG_BITS     = 3'd2,
      REG_INIT_COUNTER = 3'd3,
      REG_GLOBAL_HIST  = 3'd4,
      REG_GLOBAL_TABLE = 3'd5,
      REG_SHARE_MODE   = 3'd6,
      REG_UNUSED       = 3'd7
   } reg_index_type;

   // Shared table index modes
   localparam logic [1:0] SHARE_PC_LOW  = 2'd1;
   localparam logic [1:0] SHARE_PC_HIGH = 2'd2;

   localparam int ENTRY_COUNT   = 32;
   localparam int LINE_WIDTH    = 5;
   localparam int TAG_WIDTH     = 30;
   localparam int HIST_WIDTH    = 8;
   localparam int TABLE_WIDTH   = 13;
   localparam int CSR_WIDTH     = 5;

   localparam logic [2:0] MAX_INDEX_BITS = 3'd5;
   localparam logic [3:0] MAX_HIST_BITS  = 4'd8;
   localparam logic [4:0] MAX_TAG_BITS   = 5'd30;
   localparam logic [1:0] RESET_COUNTER  = 2'd1;
   localparam logic [1:0] TAKEN_LIMIT    = 2'd2;
   localparam logic [1:0] COUNTER_MAX    = 2'd3;
   localparam logic [31:0] INSTR_BYTES   = 32'd4;

endpackage

### hdl/two_level_branch_predictor_btb_top.sv
// Top level: two-level branch predictor with a direct-mapped branch target buffer.
//
//   channel   ports                        handshake
//   request   req_cmd, req_pc, req_*       accepted when start high and busy low
//   response  rsp_predict_taken, rsp_*     valid for one cycle while rsp_valid high
//   config    csr_write_en, csr_index, csr_wdata  written on any edge with csr_write_en high
//
// A predict, or an update that needs no counter refill, holds busy through the look-up,
// check, index and use states after it is accepted; the response shows as busy drops, and
// the next item is accepted only once busy is low again. An update that allocates an entry
// with private counter tables refills that line's counters between check and index. Init
// holds busy while it walks the counter table one entry a cycle. After reset the same sweep
// runs with busy high and no response. The receiver cannot stall responses.
module two_level_branch_predictor_btb_top
   import tlbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [31:0]           req_pc,
   input  logic [31:0]           req_actual_target,
   input  logic                  req_was_taken,
   input  logic [31:0]           req_earlier_prediction,
   output logic                  rsp_valid,
   output logic                  rsp_predict_taken,
   output logic [31:0]           rsp_predicted_target,
   output logic [31:0]           rsp_branch_count,
   output logic [31:0]           rsp_flush_count,
   input  logic                  csr_write_en,
   input  logic [2:0]            csr_index,
   input  logic [CSR_WIDTH-1:0]  csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_LOOK  = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_FILL  = 7'b0010000,
      ST_TIDX  = 7'b0100000,
      ST_TUSE  = 7'b1000000
   } state_type;

   // Configuration registers
   logic [2:0] index_bits_ff;
   logic [3:0] history_bits_ff;
   logic [4:0] tag_bits_ff;
   logic [1:0] init_counter_ff;
   logic       global_hist_ff;
   logic       global_table_ff;
   logic [1:0] share_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff   <= 3'd4;
         history_bits_ff <= 4'd8;
         tag_bits_ff     <= 5'd30;
         init_counter_ff <= RESET_COUNTER;
         global_hist_ff  <= 1'b1;
         global_table_ff <= 1'b1;
         share_mode_ff   <= 2'd0;
      end else if (csr_write_en) begin
         unique case (reg_index_type'(csr_index))
            REG_INDEX_BITS:   index_bits_ff   <= csr_wdata[2:0];
            REG_HISTORY_BITS: history_bits_ff <= csr_wdata[3:0];
            REG_TAG_BITS:     tag_bits_ff     <= csr_wdata[4:0];
            REG_INIT_COUNTER: init_counter_ff <= csr_wdata[1:0];
            REG_GLOBAL_HIST:  global_hist_ff  <= csr_wdata[0];
            REG_GLOBAL_TABLE: global_table_ff <= csr_wdata[0];
            REG_SHARE_MODE:   share_mode_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and item registers
   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff;
   logic [31:0]       pc_ff, tgt_ff, pred_ff;
   logic              taken_ff;
   logic              init_pending_ff;
   logic [TABLE_WIDTH-1:0] sweep_ff;
   logic [1:0]        fill_val_ff;
   logic [HIST_WIDTH-1:0]  fill_k_ff;
   logic              hit_ff;
   logic [TABLE_WIDTH-1:0] cidx_ff;
   logic [1:0]        cnt_rd_ff;
   logic [TAG_WIDTH-1:0]   tag_rd_ff;
   logic [31:0]       tgt_rd_ff;
   logic [31:0]       updates_ff, flushes_ff;
   logic [ENTRY_COUNT-1:0] valid_ff;
   logic [HIST_WIDTH-1:0]  hist_ff [ENTRY_COUNT];
   logic [HIST_WIDTH-1:0]  shared_hist_ff;

   logic              rsp_valid_ff, rsp_taken_ff;
   logic [31:0]       rsp_target_ff, rsp_branch_ff, rsp_flush_ff;

   // Line, tag and history geometry from the current configuration
   logic [2:0]             ib;
   logic [4:0]             tb;
   logic [3:0]             hb;
   logic [HIST_WIDTH-1:0]  hmask;
   logic [LINE_WIDTH-1:0]  line;
   logic [TAG_WIDTH-1:0]   tag;
   logic [HIST_WIDTH-1:0]  hcur, hsel, hnew;
   logic [TABLE_WIDTH-1:0] base, cidx;
   logic                   hit;
   logic                   flush;
   logic [1:0]             cnt_new;

   always_comb begin
      ib = (index_bits_ff > MAX_INDEX_BITS) ? MAX_INDEX_BITS : index_bits_ff;
      tb = (tag_bits_ff > MAX_TAG_BITS) ? MAX_TAG_BITS : tag_bits_ff;
      if (history_bits_ff == 4'd0) hb = 4'd1;
      else if (history_bits_ff > MAX_HIST_BITS) hb = MAX_HIST_BITS;
      else hb = history_bits_ff;
      hmask = HIST_WIDTH'((9'd1 << hb) - 9'd1);
      line  = pc_ff[6:2] & LINE_WIDTH'((6'd1 << ib) - 6'd1);
      tag   = pc_ff[31:2] & TAG_WIDTH'((31'd1 << tb) - 31'd1);
      hcur  = global_hist_ff ? shared_hist_ff : hist_ff[line];
      hsel  = hcur & hmask;
      hnew  = ((hcur << 1) & hmask) | HIST_WIDTH'(taken_ff);
      base  = TABLE_WIDTH'({8'd0, line} << hb);
      if (global_table_ff) begin
         if (share_mode_ff == SHARE_PC_LOW)
            cidx = TABLE_WIDTH'(hsel ^ (pc_ff[9:2] & hmask));
         else if (share_mode_ff == SHARE_PC_HIGH)
            cidx = TABLE_WIDTH'(hsel ^ (pc_ff[23:16] & hmask));
         else
            cidx = TABLE_WIDTH'(hsel);
      end else begin
         cidx = base | TABLE_WIDTH'(hsel);
      end
      hit   = valid_ff[line] && (tag_rd_ff == tag);
      flush = taken_ff ? (tgt_ff != pred_ff) : ((pc_ff + INSTR_BYTES) != pred_ff);
      if (taken_ff) cnt_new = (cnt_rd_ff < COUNTER_MAX) ? cnt_rd_ff + 2'd1 : cnt_rd_ff;
      else          cnt_new = (cnt_rd_ff > 2'd0) ? cnt_rd_ff - 2'd1 : cnt_rd_ff;
   end

   // Counter table write port select
   logic                   mem_we;
   logic [TABLE_WIDTH-1:0] mem_addr;
   logic [1:0]             mem_wdata;

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = cidx_ff;
      mem_wdata = cnt_new;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_ff;
            mem_wdata = fill_val_ff;
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_addr  = base | TABLE_WIDTH'(fill_k_ff);
            mem_wdata = init_counter_ff;
         end
         ST_TUSE: mem_we = (cmd_ff == CMD_UPDATE);
         default: ;
      endcase
   end

   // Counter table memory
   logic [1:0] cnt_mem [2**TABLE_WIDTH];
   always_ff @(posedge clock) begin
      if (mem_we) cnt_mem[mem_addr] <= mem_wdata;
      if (state_ff == ST_TIDX) cnt_rd_ff <= cnt_mem[cidx];
   end

   // Tag and target memories
   logic [TAG_WIDTH-1:0] tag_mem [ENTRY_COUNT];
   logic [31:0]          tgt_mem [ENTRY_COUNT];
   always_ff @(posedge clock) begin
      if (state_ff == ST_TUSE && cmd_ff == CMD_UPDATE) begin
         tag_mem[line] <= tag;
         tgt_mem[line] <= tgt_ff;
      end
      if (state_ff == ST_LOOK) begin
         tag_rd_ff <= tag_mem[line];
         tgt_rd_ff <= tgt_mem[line];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (start) begin
               if (req_cmd == CMD_PREDICT || req_cmd == CMD_UPDATE) state_in = ST_LOOK;
               else if (req_cmd == CMD_INIT) state_in = ST_CLEAR;
            end
         ST_CLEAR: if (&sweep_ff) state_in = ST_IDLE;
         ST_LOOK:  state_in = ST_CHECK;
         ST_CHECK:
            if (cmd_ff == CMD_UPDATE && !hit && !global_table_ff) state_in = ST_FILL;
            else state_in = ST_TIDX;
         ST_FILL:  if (fill_k_ff == hmask) state_in = ST_TIDX;
         ST_TIDX:  state_in = ST_TUSE;
         ST_TUSE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control, history, statistics and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         sweep_ff        <= '0;
         fill_val_ff     <= RESET_COUNTER;
         init_pending_ff <= 1'b0;
         valid_ff        <= '0;
         shared_hist_ff  <= '0;
         for (int i = 0; i < ENTRY_COUNT; i++) hist_ff[i] <= '0;
         updates_ff      <= '0;
         flushes_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE:
               if (start) begin
                  cmd_ff   <= req_cmd;
                  pc_ff    <= req_pc;
                  tgt_ff   <= req_actual_target;
                  taken_ff <= req_was_taken;
                  pred_ff  <= req_earlier_prediction;
                  if (req_cmd == CMD_INIT) begin
                     valid_ff        <= '0;
                     shared_hist_ff  <= '0;
                     for (int i = 0; i < ENTRY_COUNT; i++) hist_ff[i] <= '0;
                     updates_ff      <= '0;
                     flushes_ff      <= '0;
                     fill_val_ff     <= init_counter_ff;
                     sweep_ff        <= '0;
                     init_pending_ff <= 1'b1;
                  end else if (req_cmd == CMD_NOP) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_taken_ff  <= 1'b0;
                     rsp_target_ff <= '0;
                     rsp_branch_ff <= updates_ff;
                     rsp_flush_ff  <= flushes_ff;
                  end
               end
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + TABLE_WIDTH'(1);
               if (&sweep_ff && init_pending_ff) begin
                  init_pending_ff <= 1'b0;
                  rsp_valid_ff    <= 1'b1;
                  rsp_taken_ff    <= 1'b0;
                  rsp_target_ff   <= '0;
                  rsp_branch_ff   <= updates_ff;
                  rsp_flush_ff    <= flushes_ff;
               end
            end
            ST_CHECK: begin
               hit_ff    <= hit;
               fill_k_ff <= '0;
               if (cmd_ff == CMD_UPDATE && !hit && !global_hist_ff) hist_ff[line] <= '0;
            end
            ST_FILL: fill_k_ff <= fill_k_ff + HIST_WIDTH'(1);
            ST_TIDX: cidx_ff <= cidx;
            ST_TUSE: begin
               rsp_valid_ff <= 1'b1;
               if (cmd_ff == CMD_UPDATE) begin
                  valid_ff[line] <= 1'b1;
                  if (global_hist_ff) shared_hist_ff <= hnew;
                  else hist_ff[line] <= hnew;
                  updates_ff    <= updates_ff + 32'd1;
                  flushes_ff    <= flushes_ff + 32'(flush);
                  rsp_taken_ff  <= 1'b0;
                  rsp_target_ff <= '0;
                  rsp_branch_ff <= updates_ff + 32'd1;
                  rsp_flush_ff  <= flushes_ff + 32'(flush);
               end else begin
                  rsp_taken_ff  <= hit_ff && (cnt_rd_ff >= TAKEN_LIMIT);
                  rsp_target_ff <= (hit_ff && (cnt_rd_ff >= TAKEN_LIMIT)) ? tgt_rd_ff
                                                                      : pc_ff + INSTR_BYTES;
                  rsp_branch_ff <= updates_ff;
                  rsp_flush_ff  <= flushes_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predict_taken    = rsp_taken_ff;
   assign rsp_predicted_target = rsp_target_ff;
   assign rsp_branch_count     = rsp_branch_ff;
   assign rsp_flush_count      = rsp_flush_ff;

endmodule

### verif/two_level_branch_predictor_btb_top_test.sv
// Testbench for the two-level branch predictor with BTB against a local predictor.
`timescale 1ns / 100ps

module two_level_branch_predictor_btb_top_test
   import tlbp_pkg::*;
();

   typedef struct packed {
      logic        taken;
      logic [31:0] target;
      logic [31:0] branches;
      logic [31:0] flushes;
   } outcome_type;

   localparam int TABLE_DEPTH = 8192;
   localparam int POOL_SIZE   = 12;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_cmd;
   logic [31:0]          req_pc;
   logic [31:0]          req_actual_target;
   logic                 req_was_taken;
   logic [31:0]          req_earlier_prediction;
   logic                 rsp_valid;
   logic                 rsp_predict_taken;
   logic [31:0]          rsp_predicted_target;
   logic [31:0]          rsp_branch_count;
   logic [31:0]          rsp_flush_count;
   logic                 csr_write_en;
   logic [2:0]           csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;

   // Predictor copy of the registers and tables
   logic [2:0]  cfg_index_bits;
   logic [3:0]  cfg_hist_bits;
   logic [4:0]  cfg_tag_bits;
   logic [1:0]  cfg_init_ctr;
   logic        cfg_global_hist;
   logic        cfg_global_table;
   logic [1:0]  cfg_share;
   logic        line_valid [ENTRY_COUNT];
   logic [29:0] line_tag [ENTRY_COUNT];
   logic [31:0] line_target [ENTRY_COUNT];
   logic [7:0]  line_hist [ENTRY_COUNT];
   logic [7:0]  global_hist;
   logic [1:0]  ctr_table [TABLE_DEPTH];
   logic [31:0] branch_total;
   logic [31:0] flush_total;

   outcome_type pending_outcomes[$];
   int       mismatch_count;
   int       items_sent;
   int       results_checked;
   int       init_count;
   bit       idle_on;

   // Stimulus pool of branches with stable targets
   logic [31:0] pool_pc [POOL_SIZE];
   logic [31:0] pool_target [POOL_SIZE];
   logic [31:0] pool_guess [POOL_SIZE];
   int          pool_bias [POOL_SIZE];

   two_level_branch_predictor_btb_top i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic int hist_len();
      if (cfg_hist_bits < 1) return 1;
      if (cfg_hist_bits > MAX_HIST_BITS) return MAX_HIST_BITS;
      return cfg_hist_bits;
   endfunction

   function automatic int line_of(logic [31:0] pc);
      int ib;
      ib = (cfg_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : cfg_index_bits;
      return (pc >> 2) & ((1 << ib) - 1);
   endfunction

   function automatic logic [29:0] tag_of(logic [31:0] pc);
      int tb;
      logic [31:0] keep;
      tb = (cfg_tag_bits > MAX_TAG_BITS) ? MAX_TAG_BITS : cfg_tag_bits;
      keep = 32'((64'd1 << tb) - 64'd1);
      return 30'((pc >> 2) & keep);
   endfunction

   function automatic int ctr_slot(int line, logic [31:0] pc);
      int hb;
      int m;
      int h;
      hb = hist_len();
      m = (1 << hb) - 1;
      h = (cfg_global_hist ? global_hist : line_hist[line]) & m;
      if (cfg_global_table) begin
         if (cfg_share == SHARE_PC_LOW) return h ^ ((pc >> 2) & m);
         if (cfg_share == SHARE_PC_HIGH) return h ^ ((pc >> 16) & m);
         return h;
      end
      return ((line << hb) + h) & (TABLE_DEPTH - 1);
   endfunction

   function automatic void clear_tables();
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         line_valid[i] = 1'b0;
         line_tag[i] = '0;
         line_target[i] = '0;
         line_hist[i] = '0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) ctr_table[i] = cfg_init_ctr;
      global_hist = '0;
      branch_total = '0;
      flush_total = '0;
   endfunction

   // Advance the predictor by one item and return its result
   function automatic outcome_type predict_branch(cmd_type cmd, logic [31:0] pc,
                                                  logic [31:0] tgt, logic taken,
                                                  logic [31:0] guess);
      outcome_type o;
      int line;
      int hb;
      int m;
      int ci;
      int base;
      logic [7:0] h;
      logic [29:0] tag;
      line = line_of(pc);
      tag = tag_of(pc);
      o = '0;
      case (cmd)
         CMD_PREDICT: begin
            o.target = pc + INSTR_BYTES;
            if (line_valid[line] && line_tag[line] == tag) begin
               ci = ctr_slot(line, pc);
               if (ctr_table[ci] >= TAKEN_LIMIT) begin
                  o.taken = 1'b1;
                  o.target = line_target[line];
               end
            end
         end
         CMD_UPDATE: begin
            hb = hist_len();
            m = (1 << hb) - 1;
            if (!line_valid[line] || line_tag[line] != tag) begin
               if (!cfg_global_hist) line_hist[line] = '0;
               if (!cfg_global_table) begin
                  base = (line << hb) & (TABLE_DEPTH - 1);
                  for (int k = 0; k <= m; k++)
                     ctr_table[(base + k) & (TABLE_DEPTH - 1)] = cfg_init_ctr;
               end
            end
            line_tag[line] = tag;
            line_target[line] = tgt;
            line_valid[line] = 1'b1;
            branch_total++;
            if (taken ? (tgt != guess) : (pc + INSTR_BYTES != guess)) flush_total++;
            ci = ctr_slot(line, pc);
            h = cfg_global_hist ? global_hist : line_hist[line];
            h = 8'((({24'd0, h} << 1) & m) + taken);
            if (cfg_global_hist) global_hist = h;
            else line_hist[line] = h;
            if (taken) begin
               if (ctr_table[ci] < COUNTER_MAX) ctr_table[ci]++;
            end else begin
               if (ctr_table[ci] > 0) ctr_table[ci]--;
            end
         end
         CMD_INIT: clear_tables();
         default: ;
      endcase
      o.branches = branch_total;
      o.flushes = flush_total;
      return o;
   endfunction

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_valid) begin
         got = {rsp_predict_taken, rsp_predicted_target, rsp_branch_count, rsp_flush_count};
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result taken=%0b target=%h branches=%0d flushes=%0d",
                     $time, got.taken, got.target, got.branches, got.flushes);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            if (got !== want) begin
               $display({"%0t: expected taken=%0b target=%h branches=%0d flushes=%0d,",
                         " got taken=%0b target=%h branches=%0d flushes=%0d"},
                        $time, want.taken, want.target, want.branches, want.flushes,
                        got.taken, got.target, got.branches, got.flushes);
               mismatch_count++;
            end
         end
      end
   end

   // Send one item; start stays high for a following item unless a random idle gap is inserted
   task automatic send_item(cmd_type cmd, logic [31:0] pc, logic [31:0] tgt = '0,
                            logic taken = 1'b0, logic [31:0] guess = '0);
      if (idle_on && $urandom_range(99) < 32) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_pc <= pc;
      req_actual_target <= tgt;
      req_was_taken <= taken;
      req_earlier_prediction <= guess;
      do @(posedge clock); while (busy);
      pending_outcomes.push_back(predict_branch(cmd, pc, tgt, taken, guess));
      items_sent++;
      if (cmd == CMD_INIT) init_count++;
   endtask

   // Write a register once the block has drained and is idle
   task automatic write_reg(reg_index_type idx, logic [CSR_WIDTH-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0 || busy);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_INDEX_BITS:   cfg_index_bits = value[2:0];
         REG_HISTORY_BITS: cfg_hist_bits = value[3:0];
         REG_TAG_BITS:     cfg_tag_bits = value[4:0];
         REG_INIT_COUNTER: cfg_init_ctr = value[1:0];
         REG_GLOBAL_HIST:  cfg_global_hist = value[0];
         REG_GLOBAL_TABLE: cfg_global_table = value[0];
         REG_SHARE_MODE:   cfg_share = value[1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int ib, int hb, int tb, int ic, int gh, int gt, int sm);
      write_reg(REG_INDEX_BITS, CSR_WIDTH'(ib));
      write_reg(REG_HISTORY_BITS, CSR_WIDTH'(hb));
      write_reg(REG_TAG_BITS, CSR_WIDTH'(tb));
      write_reg(REG_INIT_COUNTER, CSR_WIDTH'(ic));
      write_reg(REG_GLOBAL_HIST, CSR_WIDTH'(gh));
      write_reg(REG_GLOBAL_TABLE, CSR_WIDTH'(gt));
      write_reg(REG_SHARE_MODE, CSR_WIDTH'(sm));
   endtask

   // Reset defaults: misses, allocation, address wrap, no-op command, init
   task automatic test_reset_defaults();
      send_item(CMD_PREDICT, 32'h0);
      send_item(CMD_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0);
      send_item(CMD_UPDATE, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_item(CMD_PREDICT, 32'h0);
      send_item(CMD_PREDICT, 32'hFFFF_FFFF);
      send_item(CMD_UPDATE, 32'hFFFF_FFFC, 32'h1234_5678, 1'b0, 32'h0);
      send_item(CMD_PREDICT, 32'hFFFF_FFFC);
      send_item(CMD_NOP, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
      send_item(CMD_INIT, 32'h0);
      send_item(CMD_PREDICT, 32'h0);
   endtask

   // Private history and tables, then shared ones, with out-of-range register values clamped
   task automatic test_private_tables();
      set_config(7, 15, 31, 3, 0, 0, 3);
      write_reg(REG_UNUSED, 5'h1F);
      send_item(CMD_UPDATE, 32'h0000_0040, 32'h0000_1000, 1'b1, 32'h0000_1000);
      send_item(CMD_PREDICT, 32'h0000_0040);
      send_item(CMD_UPDATE, 32'h8000_0040, 32'h0000_2000, 1'b0, 32'h0);
      send_item(CMD_PREDICT, 32'h8000_0040);
      set_config(0, 0, 0, 0, 1, 1, SHARE_PC_HIGH);
      send_item(CMD_UPDATE, 32'h0003_0004, 32'h0000_3000, 1'b1, 32'h0);
      send_item(CMD_PREDICT, 32'h0001_0008);
      send_item(CMD_INIT, 32'h0);
      send_item(CMD_PREDICT, 32'h0003_0004);
   endtask

   // One random phase: mostly predicts and updates over a pool of branches
   task automatic test_random_phase(int count, bit with_init);
      int slot;
      int roll;
      logic taken;
      logic [31:0] pc_high;
      pc_high = $urandom;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_pc[i] = ($urandom_range(3) == 0) ? $urandom
                                               : (pc_high ^ ($urandom_range(63) << 2));
         pool_target[i] = $urandom;
         pool_guess[i] = pool_pc[i] + INSTR_BYTES;
         pool_bias[i] = $urandom_range(100);
      end
      for (int n = 0; n < count; n++) begin
         idle_on = !(n >= count / 3 && n < count / 2);
         roll = $urandom_range(99);
         slot = $urandom_range(POOL_SIZE - 1);
         if (with_init && n == count / 2) begin
            send_item(CMD_INIT, $urandom);
         end else if (roll < 3) begin
            send_item(CMD_NOP, $urandom, $urandom, 1'($urandom_range(1)), $urandom);
         end else if (roll < 12) begin
            send_item(cmd_type'($urandom_range(1)), $urandom, $urandom,
                      1'($urandom_range(1)), $urandom);
         end else if (roll < 55) begin
            send_item(CMD_PREDICT, pool_pc[slot]);
            pool_guess[slot] = pending_outcomes[$].target;
         end else begin
            taken = $urandom_range(99) < pool_bias[slot];
            send_item(CMD_UPDATE, pool_pc[slot],
                      ($urandom_range(9) == 0) ? $urandom : pool_target[slot], taken,
                      ($urandom_range(4) == 0) ? $urandom : pool_guess[slot]);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start <= 1'b0;
      req_cmd <= CMD_NOP;
      req_pc <= '0;
      req_actual_target <= '0;
      req_was_taken <= 1'b0;
      req_earlier_prediction <= '0;
      csr_write_en <= 1'b0;
      csr_index <= REG_UNUSED;
      csr_wdata <= '0;
      cfg_index_bits = 3'd4;
      cfg_hist_bits = MAX_HIST_BITS;
      cfg_tag_bits = MAX_TAG_BITS;
      cfg_init_ctr = RESET_COUNTER;
      cfg_global_hist = 1'b1;
      cfg_global_table = 1'b1;
      cfg_share = 2'd0;
      clear_tables();
      mismatch_count = 0;
      items_sent = 0;
      results_checked = 0;
      init_count = 0;
      idle_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_private_tables();

      set_config(4, 8, 30, 1, 1, 1, 0);
      test_random_phase(150, 1'b0);
      set_config(5, 8, 30, 2, 0, 0, 0);
      test_random_phase(160, 1'b1);
      set_config(0, 1, 0, 0, 1, 1, SHARE_PC_LOW);
      test_random_phase(130, 1'b0);
      set_config(3, 4, 12, 3, 0, 1, SHARE_PC_HIGH);
      test_random_phase(140, 1'b1);
      set_config(2, 3, 5, 1, 1, 0, 3);
      test_random_phase(140, 1'b0);
      set_config(7, 0, 31, 2, 1, 1, SHARE_PC_HIGH);
      test_random_phase(140, 1'b0);
      set_config(1, 12, 2, 0, 0, 0, SHARE_PC_LOW);
      test_random_phase(140, 1'b1);
      set_config(5, 6, 20, 3, 1, 1, SHARE_PC_LOW);
      test_random_phase(140, 1'b0);
      set_config(4, 2, 30, 1, 0, 1, 0);
      test_random_phase(140, 1'b0);

      // Drain, then allow for a trailing counter refill
      start <= 1'b0;
      for (int w = 0; w < 100000 && pending_outcomes.size() != 0; w++) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Covered %0d items (%0d inits) over twelve register settings; %0d results checked.",
               items_sent, init_count, results_checked);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (pending_outcomes.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, pending_outcomes.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
